@@ hdl/ssu_pkg.sv @@
// Shared constants, types and elaboration-time twiddle tables for the stereo spectrum splitter.
// No dependencies; used by every module of the block except ssu_ram.
`default_nettype none

package ssu_pkg;

  localparam int SAMPLE_POINTS = 128;
  localparam int TWIDDLE_BITS  = 16;
  localparam int LOG_N         = $clog2(SAMPLE_POINTS);
  localparam int ADDR_W        = LOG_N;
  localparam int HALF_N        = SAMPLE_POINTS / 2;
  localparam int BF_W          = LOG_N - 1;
  localparam int STG_W         = (LOG_N > 2) ? $clog2(LOG_N) : 1;
  localparam int FRAC_BITS     = TWIDDLE_BITS - 1;

  localparam int SAMPLE_W      = 16;
  localparam int STORE_W       = 25;
  localparam int RAM_W         = 2 * STORE_W;
  localparam int DIFF_W        = STORE_W + 1;
  localparam int PROD_W        = DIFF_W + TWIDDLE_BITS;
  localparam int SQ_W          = 2 * DIFF_W;
  localparam int RAD_W         = SQ_W;
  localparam int NUM_W         = SQ_W + 1;
  localparam int MAG_W         = 25;
  localparam int BIN_W         = 6;
  localparam int CLAR_W        = 9;
  localparam int CLARITY_SCALE = 256;
  localparam int CLAR_SHIFT    = $clog2(CLARITY_SCALE);
  localparam int QUO_W         = CLAR_SHIFT + 1;
  localparam int DIV_W         = NUM_W + CLAR_SHIFT + 1;

  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_F_RD,
    ST_F_DIF,
    ST_F_MUL1,
    ST_F_MUL2,
    ST_F_WR,
    ST_O_RD,
    ST_O_DIF,
    ST_O_M1,
    ST_O_M2,
    ST_O_M3,
    ST_O_ST,
    ST_O_RUN,
    ST_O_EMIT
  } ssu_state_e;

  typedef logic [SAMPLE_POINTS-1:0][TWIDDLE_BITS-1:0] tw_tab_t;

  // Shift-subtract quotient, used only while building the tables.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem     = rem - {1'b0, den};
        quo[b]  = 1'b1;
      end
    end
    return quo;
  endfunction

  // Taylor series in Q30; sin_sel picks the odd series.
  function automatic logic signed [63:0] series_q30(input logic [63:0] start,
                                                    input logic [63:0] t2,
                                                    input logic sin_sel);
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic               neg;
    logic [63:0]        dv;
    term = start;
    sum  = signed'(start);
    neg  = 1'b1;
    dv   = sin_sel ? 64'd2 : 64'd1;
    for (int n = 0; n < 24; n++) begin
      if (term != 64'd0) begin
        term = udiv64((term * t2 + (64'd1 << 29)) >> 30, dv * (dv + 64'd1));
        dv   = dv + 64'd2;
        sum  = neg ? sum - signed'(term) : sum + signed'(term);
        neg  = !neg;
      end
    end
    return sum;
  endfunction

  function automatic logic [TWIDDLE_BITS-1:0] round_twiddle(input logic signed [63:0] v);
    logic [63:0] mag;
    logic [63:0] lim;
    mag = (v < 0) ? 64'(-v) : 64'(v);
    lim = (64'd1 << FRAC_BITS) - 64'd1;
    mag = (mag + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
    if (mag > lim) mag = lim;
    return (v < 0) ? TWIDDLE_BITS'(64'd0 - mag) : TWIDDLE_BITS'(mag);
  endfunction

  // {cos, sin} of 2*pi*a/128 in Q30
  function automatic logic [127:0] circle_q30(input logic [6:0] a);
    logic [1:0]         quad;
    logic [63:0]        phi;
    logic [63:0]        t2;
    logic signed [63:0] c0;
    logic signed [63:0] s0;
    logic [127:0]       res;
    quad = a[6:5];
    phi  = (64'(a[4:0]) * PI_Q30 + 64'd32) >> 6;
    t2   = (phi * phi + (64'd1 << 29)) >> 30;
    c0   = series_q30(64'd1 << 30, t2, 1'b0);
    s0   = series_q30(phi, t2, 1'b1);
    case (quad)
      2'd0:    res = {c0, s0};
      2'd1:    res = {-s0, c0};
      2'd2:    res = {-c0, -s0};
      default: res = {s0, -c0};
    endcase
    return res;
  endfunction

  // sin_sel = 0 builds the cosine table, 1 the negated sine table
  function automatic tw_tab_t build_tw(input logic sin_sel);
    tw_tab_t      tab;
    logic [127:0] cs;
    for (int m = 0; m < SAMPLE_POINTS; m++) begin
      cs = circle_q30(7'((m * (128 / SAMPLE_POINTS)) % 128));
      tab[m] = sin_sel ? round_twiddle(-signed'(cs[63:0])) : round_twiddle(signed'(cs[127:64]));
    end
    return tab;
  endfunction

  localparam tw_tab_t TW_COS  = build_tw(1'b0);
  localparam tw_tab_t TW_NSIN = build_tw(1'b1);

  function automatic logic [ADDR_W-1:0] bit_rev(input logic [ADDR_W-1:0] v);
    logic [ADDR_W-1:0] r;
    for (int b = 0; b < ADDR_W; b++) r[b] = v[ADDR_W-1-b];
    return r;
  endfunction

  function automatic logic signed [STORE_W-1:0] sat_store(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = (64'sd1 <<< (STORE_W - 1)) - 64'sd1;
    lo = -(64'sd1 <<< (STORE_W - 1));
    if (v > hi) return STORE_W'(hi);
    if (v < lo) return STORE_W'(lo);
    return STORE_W'(v);
  endfunction

endpackage

`default_nettype wire

@@ hdl/ssu_ram.sv @@
// Generic synchronous RAM: one write port, two read ports, registered read data.
// No dependencies.
`default_nettype none

module ssu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic      [WIDTH-1:0]         rdata_a_o,
  output logic      [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

`default_nettype wire

@@ hdl/ssu_isqrt.sv @@
// Digit-by-digit integer square root, two radicand bits per cycle, truncated result.
// Depends on ssu_pkg.
`default_nettype none

module ssu_isqrt (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [ssu_pkg::RAD_W-1:0]  radicand_i,
  output logic                            busy_o,
  output logic      [ssu_pkg::MAG_W-1:0]  root_o
);
  import ssu_pkg::*;

  logic [RAD_W-1:0] rem_q, res_q, bit_q;
  logic             busy_q;
  logic [RAD_W:0]   trial;
  logic             take;

  assign trial = {1'b0, res_q} + {1'b0, bit_q};
  assign take  = {1'b0, rem_q} >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
    end else if (busy_q && bit_q[0]) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= radicand_i;
      res_q <= '0;
      bit_q <= RAD_W'(1) << (RAD_W - 2);
    end else if (busy_q) begin
      if (take) begin
        rem_q <= rem_q - trial[RAD_W-1:0];
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign busy_o = busy_q;
  // saturate at the largest magnitude code
  assign root_o = (|res_q[RAD_W-1:MAG_W]) ? '1 : res_q[MAG_W-1:0];

endmodule

`default_nettype wire

@@ hdl/stereo_fft_spectrum_split_unit.sv @@
// Stereo spectrum splitter: sample load, in-place radix-2 DIF FFT, per-bin spectrum split.
// Depends on ssu_pkg, ssu_ram and ssu_isqrt.
//
// Input channel: one beat carries a left/right PCM pair. SAMPLE_POINTS beats form a
// frame and are taken at one per cycle while the block is loading (in_stall_o low).
// After the final beat of a frame the block stalls its input, runs the FFT in place
// in a single 50-bit wide RAM (SAMPLE_POINTS/2*log2 butterflies, each a read, a difference,
// two multiply steps and a write) and then produces one result beat per bin 1..N/2-1.
// Each bin runs RAM read, difference, paired multiplies, root start, the 26-step square
// root (two units, left and right) with the clarity divider in parallel, and emit.
// Frame throughput is set by the shared butterfly datapath and the iterative root.
// The result register lets the block load the next frame while the last bin waits.
// If the receiver stalls, the current result holds and the bin sequencer waits.
// Reset clears the sequencer, frame counter and output valid; RAM contents are not
// cleared, every entry is written by the load before the FFT reads it.
`default_nettype none

module stereo_fft_spectrum_split_unit (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic signed [ssu_pkg::SAMPLE_W-1:0]  left_sample_i,
  input  wire logic signed [ssu_pkg::SAMPLE_W-1:0]  right_sample_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic             [ssu_pkg::BIN_W-1:0]     bin_index_o,
  output logic             [ssu_pkg::MAG_W-1:0]     left_magnitude_o,
  output logic             [ssu_pkg::MAG_W-1:0]     right_magnitude_o,
  output logic signed      [ssu_pkg::CLAR_W-1:0]    clarity_o,
  output logic                                      last_o
);
  import ssu_pkg::*;

  localparam int CNT_W = $clog2(QUO_W + 1);
  localparam logic signed [63:0] ROUND_HALF = 64'sd1 <<< (FRAC_BITS - 1);

  ssu_state_e state_q, state_d;

  logic [ADDR_W-1:0] load_cnt_q;
  logic [STG_W-1:0]  stage_q;
  logic [BF_W-1:0]   bfly_q;
  logic [ADDR_W-1:0] kbin_q;

  // RAM port
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr_a, ram_raddr_b;
  logic [RAM_W-1:0]  ram_wdata, rd_a, rd_b;
  logic signed [STORE_W-1:0] a_re, a_im, b_re, b_im;

  // butterfly datapath
  logic [ADDR_W-1:0]  addr_i_q, addr_l_q;
  logic signed [TWIDDLE_BITS-1:0] tw_c_q, tw_s_q;
  logic signed [STORE_W-1:0] sum_re_q, sum_im_q, rot_re_q, rot_im;
  logic signed [DIFF_W-1:0]  xt_q, yt_q;
  logic signed [PROD_W-1:0]  p0_q, p1_q;

  // butterfly addressing
  logic [STG_W-1:0]  kpos;
  logic [ADDR_W-1:0] b_ext, n2, lo_mask, idx_i, idx_l, tw_idx;

  // bin datapath
  logic signed [DIFF_W-1:0] sx_q, dx_q, sy_q, dy_q;
  logic signed [SQ_W-1:0]   ma_q, mb_q;
  logic [RAD_W-1:0]         aa_q, bb_q;
  logic signed [NUM_W-1:0]  num_c;
  logic [NUM_W-1:0]         num_mag;
  logic [RAD_W:0]           den_c;

  // clarity divider
  logic [DIV_W-1:0] dv_rem_q, dv_den_q;
  logic [QUO_W-1:0] dv_quo_q;
  logic [CNT_W-1:0] dv_cnt_q;
  logic             neg_q, den_zero_q;
  logic signed [CLAR_W-1:0] clar_c;

  logic sq_start, sq_l_busy, sq_r_busy;
  logic [MAG_W-1:0] mag_l, mag_r;

  logic in_accept, out_load;

  assign in_stall_o = (state_q != ST_LOAD);
  assign in_accept  = in_valid_i && !in_stall_o;

  assign a_re = rd_a[RAM_W-1:STORE_W];
  assign a_im = rd_a[STORE_W-1:0];
  assign b_re = rd_b[RAM_W-1:STORE_W];
  assign b_im = rd_b[STORE_W-1:0];

  // insert a zero at the butterfly span bit to get the upper leg
  assign kpos    = STG_W'(LOG_N - 1) - stage_q;
  assign b_ext   = ADDR_W'(bfly_q);
  assign n2      = ADDR_W'(1) << kpos;
  assign lo_mask = n2 - ADDR_W'(1);
  assign idx_i   = (((b_ext >> kpos) << kpos) << 1) | (b_ext & lo_mask);
  assign idx_l   = idx_i | n2;
  assign tw_idx  = (b_ext & lo_mask) << stage_q;

  assign rot_im = sat_store((64'(p0_q) + 64'(p1_q) + ROUND_HALF) >>> FRAC_BITS);

  assign num_c   = NUM_W'(ma_q) + NUM_W'(mb_q);
  assign num_mag = (num_c < 0) ? NUM_W'(-num_c) : NUM_W'(num_c);
  assign den_c   = {1'b0, aa_q} + {1'b0, bb_q};

  assign clar_c = den_zero_q ? '0 :
                  neg_q ? CLAR_W'(CLAR_W'(0) - CLAR_W'(dv_quo_q)) : CLAR_W'(dv_quo_q);

  ssu_ram #(
    .WIDTH (RAM_W),
    .DEPTH (SAMPLE_POINTS)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .raddr_a_i (ram_raddr_a),
    .raddr_b_i (ram_raddr_b),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  ssu_isqrt u_sqrt_l (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sq_start),
    .radicand_i (aa_q),
    .busy_o     (sq_l_busy),
    .root_o     (mag_l)
  );

  ssu_isqrt u_sqrt_r (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sq_start),
    .radicand_i (bb_q),
    .busy_o     (sq_r_busy),
    .root_o     (mag_r)
  );

  // next state, RAM control, root start and result load
  always_comb begin
    state_d     = state_q;
    ram_we      = 1'b0;
    ram_waddr   = load_cnt_q;
    ram_wdata   = {STORE_W'(left_sample_i), STORE_W'(right_sample_i)};
    ram_raddr_a = idx_i;
    ram_raddr_b = idx_l;
    sq_start    = 1'b0;
    out_load    = 1'b0;
    case (state_q)
      ST_LOAD: begin
        if (in_accept) begin
          ram_we = 1'b1;
          if (load_cnt_q == ADDR_W'(SAMPLE_POINTS - 1)) state_d = ST_F_RD;
        end
      end
      ST_F_RD:   state_d = ST_F_DIF;
      ST_F_DIF:  state_d = ST_F_MUL1;
      ST_F_MUL1: begin
        ram_we    = 1'b1;
        ram_waddr = addr_i_q;
        ram_wdata = {sum_re_q, sum_im_q};
        state_d   = ST_F_MUL2;
      end
      ST_F_MUL2: state_d = ST_F_WR;
      ST_F_WR: begin
        ram_we    = 1'b1;
        ram_waddr = addr_l_q;
        ram_wdata = {rot_re_q, rot_im};
        if (bfly_q == BF_W'(HALF_N - 1) && stage_q == STG_W'(LOG_N - 1)) begin
          state_d = ST_O_RD;
        end else begin
          state_d = ST_F_RD;
        end
      end
      ST_O_RD: begin
        ram_raddr_a = bit_rev(kbin_q);
        ram_raddr_b = bit_rev(ADDR_W'(SAMPLE_POINTS) - kbin_q);
        state_d     = ST_O_DIF;
      end
      ST_O_DIF: state_d = ST_O_M1;
      ST_O_M1:  state_d = ST_O_M2;
      ST_O_M2:  state_d = ST_O_M3;
      ST_O_M3:  state_d = ST_O_ST;
      ST_O_ST: begin
        sq_start = 1'b1;
        state_d  = ST_O_RUN;
      end
      ST_O_RUN: begin
        if (!sq_l_busy && !sq_r_busy && dv_cnt_q == '0) state_d = ST_O_EMIT;
      end
      ST_O_EMIT: begin
        // hold until the result register is free
        if (!out_valid_o || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = (kbin_q == ADDR_W'(HALF_N - 1)) ? ST_LOAD : ST_O_RD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      load_cnt_q  <= '0;
      stage_q     <= '0;
      bfly_q      <= '0;
      kbin_q      <= '0;
      dv_cnt_q    <= '0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_accept) load_cnt_q <= load_cnt_q + ADDR_W'(1);
      if (state_q == ST_F_WR) begin
        if (bfly_q == BF_W'(HALF_N - 1)) begin
          bfly_q  <= '0;
          stage_q <= (stage_q == STG_W'(LOG_N - 1)) ? '0 : stage_q + STG_W'(1);
        end else begin
          bfly_q <= bfly_q + BF_W'(1);
        end
      end
      if (state_q == ST_LOAD) begin
        kbin_q <= ADDR_W'(1);
      end else if (out_load) begin
        kbin_q <= kbin_q + ADDR_W'(1);
      end
      if (state_q == ST_O_ST) begin
        dv_cnt_q <= CNT_W'(QUO_W);
      end else if (dv_cnt_q != '0) begin
        dv_cnt_q <= dv_cnt_q - CNT_W'(1);
      end
      if (out_load) begin
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_F_RD: begin
        addr_i_q <= idx_i;
        addr_l_q <= idx_l;
        tw_c_q   <= TW_COS[tw_idx];
        tw_s_q   <= TW_NSIN[tw_idx];
      end
      ST_F_DIF: begin
        sum_re_q <= sat_store(64'(a_re) + 64'(b_re));
        sum_im_q <= sat_store(64'(a_im) + 64'(b_im));
        xt_q     <= DIFF_W'(a_re) - DIFF_W'(b_re);
        yt_q     <= DIFF_W'(a_im) - DIFF_W'(b_im);
      end
      ST_F_MUL1: begin
        p0_q <= xt_q * tw_c_q;
        p1_q <= yt_q * tw_s_q;
      end
      ST_F_MUL2: begin
        rot_re_q <= sat_store((64'(p0_q) - 64'(p1_q) + ROUND_HALF) >>> FRAC_BITS);
        p0_q     <= xt_q * tw_s_q;
        p1_q     <= yt_q * tw_c_q;
      end
      ST_O_DIF: begin
        sx_q <= DIFF_W'(a_re) + DIFF_W'(b_re);
        dx_q <= DIFF_W'(a_re) - DIFF_W'(b_re);
        sy_q <= DIFF_W'(a_im) + DIFF_W'(b_im);
        dy_q <= DIFF_W'(a_im) - DIFF_W'(b_im);
      end
      ST_O_M1: begin
        ma_q <= sx_q * sx_q;
        mb_q <= dy_q * dy_q;
      end
      ST_O_M2: begin
        aa_q <= $unsigned(ma_q) + $unsigned(mb_q);
        ma_q <= dx_q * dx_q;
        mb_q <= sy_q * sy_q;
      end
      ST_O_M3: begin
        bb_q <= $unsigned(ma_q) + $unsigned(mb_q);
        ma_q <= sx_q * dx_q;
        mb_q <= sy_q * dy_q;
      end
      ST_O_ST: begin
        dv_rem_q   <= DIV_W'(num_mag) << CLAR_SHIFT;
        dv_den_q   <= DIV_W'(den_c) << CLAR_SHIFT;
        dv_quo_q   <= '0;
        neg_q      <= num_c < 0;
        den_zero_q <= den_c == '0;
      end
      default: ;
    endcase
    // one quotient bit per cycle
    if (state_q == ST_O_RUN && dv_cnt_q != '0) begin
      if (dv_rem_q >= dv_den_q) begin
        dv_rem_q <= dv_rem_q - dv_den_q;
        dv_quo_q <= {dv_quo_q[QUO_W-2:0], 1'b1};
      end else begin
        dv_quo_q <= {dv_quo_q[QUO_W-2:0], 1'b0};
      end
      dv_den_q <= dv_den_q >> 1;
    end
    if (out_load) begin
      bin_index_o       <= BIN_W'(kbin_q);
      left_magnitude_o  <= mag_l;
      right_magnitude_o <= mag_r;
      clarity_o         <= clar_c;
      last_o            <= (kbin_q == ADDR_W'(HALF_N - 1));
    end
  end

endmodule

`default_nettype wire

@@ hdl/ssu_checker.sv @@
// Port-level checks for the stereo spectrum splitter, bound to the top level.
// Depends on ssu_pkg and stereo_fft_spectrum_split_unit.
`default_nettype none

module ssu_checker (
  input wire logic                                 clk_i,
  input wire logic                                 rst_ni,
  input wire logic                                 in_valid_i,
  input wire logic                                 in_stall_o,
  input wire logic signed [ssu_pkg::SAMPLE_W-1:0]  left_sample_i,
  input wire logic signed [ssu_pkg::SAMPLE_W-1:0]  right_sample_i,
  input wire logic                                 out_valid_o,
  input wire logic                                 out_stall_i,
  input wire logic        [ssu_pkg::BIN_W-1:0]     bin_index_o,
  input wire logic        [ssu_pkg::MAG_W-1:0]     left_magnitude_o,
  input wire logic        [ssu_pkg::MAG_W-1:0]     right_magnitude_o,
  input wire logic signed [ssu_pkg::CLAR_W-1:0]    clarity_o,
  input wire logic                                 last_o
);
  import ssu_pkg::*;

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(bin_index_o))
    else $error("stalled result beat dropped or changed");

  a_last_bin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_o == (bin_index_o == BIN_W'(HALF_N - 1))) && bin_index_o != '0)
    else $error("bin number and last flag disagree");

  // the input stays closed until the final bin of a frame is out
  a_frame_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> in_stall_o)
    else $error("input opened before the frame finished");

  a_clar_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> clarity_o >= -CLAR_W'(CLARITY_SCALE / 2) &&
                    clarity_o <= CLAR_W'(CLARITY_SCALE / 2))
    else $error("clarity out of range");

endmodule

bind stereo_fft_spectrum_split_unit ssu_checker u_ssu_checker (.*);

`default_nettype wire
